[design/lir_pkg.sv]
// ============================================================================
// lir_pkg - shared types and constants of the linear interpolation resampler
// Block geometry, weight step constants and the job/result records passed
// between the front end, the job queue and the interpolation back end.
// ============================================================================
package lir_pkg;

    // Block geometry
    localparam int IN_PER_BLOCK  = 2100;
    localparam int OUT_PER_BLOCK = 2048;

    // Per-output phase step: whole samples and fractional remainder
    localparam int STEP_WHOLE = IN_PER_BLOCK / OUT_PER_BLOCK;
    localparam int STEP_FRAC  = IN_PER_BLOCK % OUT_PER_BLOCK;

    // Weight step: STEP_FRAC * 65536 = WEIGHT_STEP * OUT_PER_BLOCK + WEIGHT_REM
    localparam int WEIGHT_STEP = (STEP_FRAC * 65536) / OUT_PER_BLOCK;
    localparam int WEIGHT_REM  = (STEP_FRAC * 65536) % OUT_PER_BLOCK;

    // Sized forms used by the front end
    localparam logic [11:0] IN_LIMIT   = 12'(IN_PER_BLOCK);
    localparam logic [11:0] OUT_LIMIT  = 12'(OUT_PER_BLOCK);
    localparam logic [11:0] WHOLE_INC  = 12'(STEP_WHOLE);
    localparam logic [11:0] FRAC_INC   = 12'(STEP_FRAC);
    localparam logic [15:0] W_INC      = 16'(WEIGHT_STEP);
    localparam logic [11:0] W_REM_INC  = 12'(WEIGHT_REM);
    localparam logic [10:0] LAST_INDEX = 11'(OUT_PER_BLOCK - 1);

    // Queue geometry (depth is a power of two so pointers wrap by themselves)
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One interpolation job: base pair, weight and block-end flag
    typedef struct packed {
        logic signed [11:0] a_i;
        logic signed [11:0] a_q;
        logic signed [11:0] b_i;
        logic signed [11:0] b_q;
        logic [15:0]        weight;
        logic               last;
    } t_job;

    // Job transaction with its valid flag
    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_xfer;

    // One result record
    typedef struct packed {
        logic signed [15:0] out_i;
        logic signed [15:0] out_q;
        logic               block_end;
    } t_res;

endpackage

[design/lir_front.sv]
// ============================================================================
// lir_front - sample intake and output scheduling
// Tracks the position within the resampling block, decides per sample
// whether an output falls due, and issues an interpolation job for it.
// ============================================================================
module lir_front
    import lir_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [11:0] i_sample_i,
    input  logic signed [11:0] i_sample_q,
    input  logic               i_queue_full,
    output t_job_xfer          o_job
);

    logic signed [11:0] r_prev_i, n_prev_i;
    logic signed [11:0] r_prev_q, n_prev_q;
    logic [11:0]        r_pos, n_pos;
    logic [10:0]        r_count, n_count;
    logic [11:0]        r_base, n_base;
    logic [10:0]        r_rem, n_rem;
    logic [15:0]        r_weight, n_weight;
    logic [10:0]        r_wrem, n_wrem;

    logic accept;
    logic emit;

    assign full   = i_queue_full;
    assign accept = push && !i_queue_full;
    assign emit   = (r_pos != 12'd0) && (r_base < r_pos) && (r_base < IN_LIMIT);

    // Job issued for the current sample
    always_comb begin
        o_job.valid      = accept && emit;
        o_job.job.a_i    = r_prev_i;
        o_job.job.a_q    = r_prev_q;
        o_job.job.b_i    = i_sample_i;
        o_job.job.b_q    = i_sample_q;
        o_job.job.weight = r_weight;
        o_job.job.last   = (r_count == LAST_INDEX);
    end

    // Phase, weight and block position update
    always_comb begin
        logic [11:0] rem_sum;
        logic        wrap;
        logic [12:0] base_sum;
        logic [11:0] wrem_sum;
        logic        wcarry;

        n_prev_i = r_prev_i;
        n_prev_q = r_prev_q;
        n_pos    = r_pos;
        n_count  = r_count;
        n_base   = r_base;
        n_rem    = r_rem;
        n_weight = r_weight;
        n_wrem   = r_wrem;

        rem_sum  = {1'b0, r_rem} + FRAC_INC;
        wrap     = (rem_sum >= OUT_LIMIT);
        if (wrap) begin
            rem_sum = rem_sum - OUT_LIMIT;
        end
        base_sum = {1'b0, r_base} + {1'b0, WHOLE_INC} + {12'd0, wrap};
        wrem_sum = {1'b0, r_wrem} + W_REM_INC;
        wcarry   = (wrem_sum >= OUT_LIMIT);
        if (wcarry) begin
            wrem_sum = wrem_sum - OUT_LIMIT;
        end

        if (accept) begin
            if (emit) begin
                n_rem = rem_sum[10:0];
                if (base_sum > {1'b0, IN_LIMIT}) begin
                    n_base = IN_LIMIT;
                end else begin
                    n_base = base_sum[11:0];
                end
                // weight wraps by exactly 2^16 when the remainder wraps
                n_weight = r_weight + W_INC + {15'd0, wcarry};
                n_wrem   = wrem_sum[10:0];
                n_count  = r_count + 11'd1;
            end
            if (r_pos >= IN_LIMIT) begin
                n_pos    = 12'd1;
                n_count  = 11'd0;
                n_base   = 12'd0;
                n_rem    = 11'd0;
                n_weight = 16'd0;
                n_wrem   = 11'd0;
            end else begin
                n_pos = r_pos + 12'd1;
            end
            n_prev_i = i_sample_i;
            n_prev_q = i_sample_q;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_i <= '0;
            r_prev_q <= '0;
            r_pos    <= '0;
            r_count  <= '0;
            r_base   <= '0;
            r_rem    <= '0;
            r_weight <= '0;
            r_wrem   <= '0;
        end else begin
            r_prev_i <= n_prev_i;
            r_prev_q <= n_prev_q;
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_base   <= n_base;
            r_rem    <= n_rem;
            r_weight <= n_weight;
            r_wrem   <= n_wrem;
        end
    end

`ifndef SYNTH
    // remainders stay below the output count
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_rem} < OUT_LIMIT) && ({1'b0, r_wrem} < OUT_LIMIT))
        else $error("phase remainder out of range");
    // base never runs past the block end
    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base <= IN_LIMIT)
        else $error("next base beyond block");
    // a stalled sample leaves the schedule untouched
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && i_queue_full) |=> $stable(r_pos) && $stable(r_base))
        else $error("schedule moved on a stalled sample");
`endif

endmodule

[design/lir_queue.sv]
// ============================================================================
// lir_queue - job queue between front end and back end
// Small FIFO of interpolation jobs so that the intake and the arithmetic
// can stall independently.
// ============================================================================
module lir_queue
    import lir_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job_xfer i_job,
    output logic      o_full,
    output t_job_xfer o_job,
    input  logic      i_pop
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, n_wr;
    logic [QUEUE_AW-1:0] r_rd, n_rd;
    logic [QUEUE_AW:0]   r_count, n_count;

    logic do_push;
    logic do_pop;

    assign o_full    = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_job.valid = (r_count != '0);
    assign o_job.job = r_mem[r_rd];
    assign do_push   = i_job.valid && !o_full;
    assign do_pop    = i_pop && o_job.valid;

    // Pointer and occupancy update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = r_wr + QUEUE_AW'(1);
        end
        if (do_pop) begin
            n_rd = r_rd + QUEUE_AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + (QUEUE_AW+1)'(1);
            2'b01:   n_count = r_count - (QUEUE_AW+1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job.job;
        end
    end

`ifndef SYNTH
    // the front end never offers a job into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_job.valid && o_full))
        else $error("job offered to full queue");
`endif

endmodule

[design/lir_back.sv]
// ============================================================================
// lir_back - interpolation datapath and result queue
// Multiplies the sample difference by the weight, adds the scaled base
// sample, floors to Q1.15 and holds results until they are taken.
// ============================================================================
module lir_back
    import lir_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_job_xfer          i_job,
    output logic               o_pop,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_out_i,
    output logic signed [15:0] o_out_q,
    output logic               o_block_end
);

    // Multiply stage registers
    logic               r_s1_v;
    logic signed [11:0] r_a_i;
    logic signed [11:0] r_a_q;
    logic signed [29:0] r_prod_i;
    logic signed [29:0] r_prod_q;
    logic               r_last;

    // Result queue
    t_res                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_count;

    logic               res_full;
    logic               advance;
    logic               res_push;
    logic               res_pop;
    logic signed [12:0] diff_i;
    logic signed [12:0] diff_q;
    logic signed [16:0] weight_s;
    logic signed [29:0] n_prod_i;
    logic signed [29:0] n_prod_q;
    logic signed [30:0] sum_i;
    logic signed [30:0] sum_q;
    t_res               res;

    assign res_full = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign advance  = !r_s1_v || !res_full;
    assign o_pop    = i_job.valid && advance;
    assign res_push = r_s1_v && !res_full;
    assign res_pop  = pop && !empty;

    // Difference times weight
    assign diff_i   = {i_job.job.b_i[11], i_job.job.b_i} - {i_job.job.a_i[11], i_job.job.a_i};
    assign diff_q   = {i_job.job.b_q[11], i_job.job.b_q} - {i_job.job.a_q[11], i_job.job.a_q};
    assign weight_s = $signed({1'b0, i_job.job.weight});
    assign n_prod_i = diff_i * weight_s;
    assign n_prod_q = diff_q * weight_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (advance) begin
            r_s1_v <= i_job.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_i    <= i_job.job.a_i;
            r_a_q    <= i_job.job.a_q;
            r_prod_i <= n_prod_i;
            r_prod_q <= n_prod_q;
            r_last   <= i_job.job.last;
        end
    end

    // Base * 65536 plus product, floored by 4096
    assign sum_i = $signed({{3{r_a_i[11]}}, r_a_i, 16'h0000}) + 31'(r_prod_i);
    assign sum_q = $signed({{3{r_a_q[11]}}, r_a_q, 16'h0000}) + 31'(r_prod_q);

    always_comb begin
        res.out_i     = sum_i[27:12];
        res.out_q     = sum_q[27:12];
        res.block_end = r_last;
    end

    // Result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (res_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (res_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            case ({res_push, res_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_mem[r_wr] <= res;
        end
    end

    assign empty       = (r_count == '0);
    assign o_out_i     = r_mem[r_rd].out_i;
    assign o_out_q     = r_mem[r_rd].out_q;
    assign o_block_end = r_mem[r_rd].block_end;

`ifndef SYNTH
    // a computed product is held while the result queue is full
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && res_full) |=> r_s1_v && $stable(r_prod_i) && $stable(r_prod_q))
        else $error("product dropped under backpressure");
    // result queue occupancy bounded by its depth
    a_res_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("result queue overflow");
`endif

endmodule

[design/linear_interp_iq_resampler.sv]
// ============================================================================
// linear_interp_iq_resampler - blockwise linear interpolation I/Q resampler
// Top level: intake/scheduling front end, job queue, interpolation back end.
// ============================================================================
// One complex sample is accepted per clock cycle while full is low; each
// sample yields zero or one interpolated Q1.15 result. Every block turns
// IN_PER_BLOCK new samples into OUT_PER_BLOCK results, with block_end on the
// last. A result is registered in the job queue and then in the multiply stage
// before it is written to the output queue, and results leave at up to one
// per cycle while pop is held. full rises only when the four-entry job
// queue is full, which happens when the four-entry result queue has been
// left unread.
module linear_interp_iq_resampler
    import lir_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [11:0] i_sample_i,
    input  logic signed [11:0] i_sample_q,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_out_i,
    output logic signed [15:0] o_out_q,
    output logic               o_block_end
);

    t_job_xfer front_job;
    t_job_xfer queue_job;
    logic      queue_full;
    logic      queue_pop;

    lir_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_sample_i   (i_sample_i),
        .i_sample_q   (i_sample_q),
        .i_queue_full (queue_full),
        .o_job        (front_job)
    );

    lir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (front_job),
        .o_full  (queue_full),
        .o_job   (queue_job),
        .i_pop   (queue_pop)
    );

    lir_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (queue_job),
        .o_pop       (queue_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out_i     (o_out_i),
        .o_out_q     (o_out_q),
        .o_block_end (o_block_end)
    );

endmodule
